/* sv/tse_pkg.sv */
// tse_pkg: shared constants and alphabet lookup for the timestamp identifier encoder
// no dependencies
package tse_pkg;

    localparam int unsigned FILE_W  = 63;
    localparam int unsigned EPOCH_W = 38;
    localparam int unsigned NS_W    = 30;
    localparam int unsigned DIG_N   = 19;
    localparam int unsigned DIG_W   = 5;

    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    function automatic logic [7:0] code_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            c = 8'h2D;
            if (v < 6'd26)
                c = 8'h41 + {2'b00, v};
            else if (v < 6'd30)
                c = 8'h30 + {2'b00, v - 6'd26};
            else if (v < 6'd56)
                c = 8'h61 + {2'b00, v - 6'd30};
            else if (v < 6'd62)
                c = 8'h34 + {2'b00, v - 6'd56};
            else if (v == 6'd62)
                c = 8'h30;
            return c;
        end
    endfunction

endpackage

/* sv/tse_bcd.sv */
// tse_bcd: serial double-dabble binary to bcd, one input bit per cycle
// depends on tse_pkg
module tse_bcd
    import tse_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [FILE_W-1:0]       value,
    output logic                    done,
    output logic [DIG_N*4-1:0]      bcd
);

    logic [FILE_W-1:0]  sh_reg, sh_next;
    logic [DIG_N*4-1:0] bcd_reg, bcd_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIG_N*4-1:0] adj;

    always_comb
    begin
        for (int i = 0; i < DIG_N; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] > 4'd4) ? bcd_reg[i*4 +: 4] + 4'd3
                                                       : bcd_reg[i*4 +: 4];
        end
        sh_next   = sh_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next   = value;
            bcd_next  = '0;
            cnt_next  = 6'(FILE_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[DIG_N*4-2:0], sh_reg[FILE_W-1]};
            sh_next  = {sh_reg[FILE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

/* sv/tse_cal.sv */
// tse_cal: serial calendar conversion by restoring division, hour/minute/second split and year/month walks
// depends on tse_pkg
module tse_cal
    import tse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [EPOCH_W-1:0]  secs,
    output logic                done,
    output logic [17:0]         year,
    output logic [3:0]          month0,
    output logic [4:0]          mday0,
    output logic [4:0]          hour,
    output logic [5:0]          minute,
    output logic [5:0]          second
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SPLIT, S_YEAR, S_MONTH, S_DONE
    } state_t;

    state_t             state_reg;
    logic [EPOCH_W-1:0] q_reg;
    logic [16:0]        r_reg;
    logic [5:0]         cnt_reg;
    logic [21:0]        days_reg;
    logic [17:0]        year_reg;
    logic [3:0]         mon_reg;
    logic [4:0]         hour_reg;
    logic [5:0]         min_reg;
    logic [5:0]         sec_reg;
    logic [2:0]         y4_reg;
    logic [6:0]         y100_reg;
    logic [1:0]         y400_reg;
    logic               leap_reg;

    logic [17:0] r_try;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        leap;

    assign r_try = {r_reg, q_reg[EPOCH_W-1]};

    always_comb
    begin
        leap = (y4_reg == 3'd0) && ((y100_reg != 7'd0) || (y400_reg == 2'd0));
        ylen = leap ? 9'd366 : 9'd365;
        case (mon_reg)
            4'd1:    mlen = leap_reg ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: mlen = 5'd30;
            default: mlen = 5'd31;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        q_reg     <= secs;
                        r_reg     <= '0;
                        cnt_reg   <= 6'(EPOCH_W - 1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (r_try >= 18'd86400)
                    begin
                        r_reg <= 17'(r_try - 18'd86400);
                        q_reg <= {q_reg[EPOCH_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= r_try[16:0];
                        q_reg <= {q_reg[EPOCH_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= S_SPLIT;
                        hour_reg  <= '0;
                        min_reg   <= '0;
                    end
                end
                S_SPLIT:
                begin
                    if (r_reg >= 17'd3600)
                    begin
                        r_reg    <= r_reg - 17'd3600;
                        hour_reg <= hour_reg + 5'd1;
                    end
                    else if (r_reg >= 17'd60)
                    begin
                        r_reg   <= r_reg - 17'd60;
                        min_reg <= min_reg + 6'd1;
                    end
                    else
                    begin
                        sec_reg  <= r_reg[5:0];
                        days_reg <= q_reg[21:0];
                        year_reg <= 18'd1970;
                        y4_reg   <= 3'd2;
                        y100_reg <= 7'd70;
                        y400_reg <= 2'd3;
                        state_reg <= S_YEAR;
                    end
                end
                S_YEAR:
                begin
                    if (days_reg >= 22'(ylen) && days_reg >= 22'd146097 &&
                        y4_reg == 3'd0 && y100_reg == 7'd0 && y400_reg == 2'd0)
                    begin
                        days_reg <= days_reg - 22'd146097;
                        year_reg <= year_reg + 18'd400;
                    end
                    else if (days_reg >= 22'(ylen))
                    begin
                        days_reg <= days_reg - 22'(ylen);
                        year_reg <= year_reg + 18'd1;
                        y4_reg   <= (y4_reg == 3'd3) ? 3'd0 : y4_reg + 3'd1;
                        if (y100_reg == 7'd99)
                        begin
                            y100_reg <= 7'd0;
                            y400_reg <= y400_reg + 2'd1;
                        end
                        else
                            y100_reg <= y100_reg + 7'd1;
                    end
                    else
                    begin
                        leap_reg  <= leap;
                        mon_reg   <= '0;
                        state_reg <= S_MONTH;
                    end
                end
                S_MONTH:
                begin
                    if (days_reg >= 22'(mlen))
                    begin
                        days_reg <= days_reg - 22'(mlen);
                        mon_reg  <= mon_reg + 4'd1;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done   = (state_reg == S_DONE);
    assign year   = year_reg;
    assign month0 = mon_reg;
    assign mday0  = days_reg[4:0];
    assign hour   = hour_reg;
    assign minute = min_reg;
    assign second = sec_reg;

endmodule

/* sv/timestamp_id_string_encoder.sv */
// timestamp_id_string_encoder: top level, serial digit and calendar units plus output sequencer
// depends on tse_pkg, tse_bcd, tse_cal
// One word in (file_number, epoch_seconds, nanoseconds) yields 10 to 33 character words, the
// final one flagged by last. Items are handled one at a time. The 'S' word is ready the cycle
// after acceptance. The decimal conversion works one bit of the file number at a time,
// running alongside the calendar unit: a serial division by 86400, a split into hours,
// minutes and seconds, a year walk (one year or one 400-year cycle per step) and a month walk.
// The remaining characters then leave one per cycle when not stalled. in_stall stays high
// from acceptance until the last character is loaded.
module timestamp_id_string_encoder
    import tse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FILE_W-1:0]  file_number,
    input  logic [EPOCH_W-1:0] epoch_seconds,
    input  logic [NS_W-1:0]    nanoseconds,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         character,
    output logic               last
);

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_DIGITS, S_CODES} state_t;

    state_t             state_reg;
    logic               bcd_ok_reg, cal_ok_reg;
    logic [DIG_N*4-1:0] dig_reg;
    logic [4:0]         dcnt_reg;
    logic [4:0]         lead_reg;
    logic [77:0]        code_reg;
    logic [3:0]         ccnt_reg;
    logic [NS_W-1:0]    ns_reg;
    logic               ov_reg;
    logic [7:0]         ch_reg;
    logic               last_reg;

    logic               start;
    logic               bcd_done, cal_done;
    logic [DIG_N*4-1:0] bcd;
    logic [17:0]        year;
    logic [3:0]         month0;
    logic [4:0]         mday0, hour;
    logic [5:0]         minute, second;
    logic               free;
    logic               load_out;
    logic [4:0]         lead;

    assign start    = in_valid && !in_stall;
    assign free     = !ov_reg || !out_stall;
    assign load_out = free && ((state_reg == S_IDLE && start) || state_reg == S_DIGITS
                               || state_reg == S_CODES);

    tse_bcd u_bcd (
        .clk(clk), .rst_n(rst_n), .start(start), .value(file_number),
        .done(bcd_done), .bcd(bcd)
    );

    tse_cal u_cal (
        .clk(clk), .rst_n(rst_n), .start(start), .secs(epoch_seconds),
        .done(cal_done), .year(year), .month0(month0), .mday0(mday0),
        .hour(hour), .minute(minute), .second(second)
    );

    // count of leading zero digits, keeping at least one digit
    always_comb
    begin
        lead = 5'd0;
        for (int i = DIG_N - 1; i >= 1; i--)
        begin
            if (bcd[i*4 +: 4] == 4'd0 && lead == 5'(DIG_N - 1 - i))
                lead = 5'(DIG_N - i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ov_reg     <= 1'b0;
            bcd_ok_reg <= 1'b0;
            cal_ok_reg <= 1'b0;
            dcnt_reg   <= '0;
            ccnt_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            if (load_out)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        ns_reg     <= nanoseconds;
                        bcd_ok_reg <= 1'b0;
                        cal_ok_reg <= 1'b0;
                        state_reg  <= S_CONV;
                        ch_reg     <= CHAR_S;
                        last_reg   <= 1'b0;
                    end
                end
                S_CONV:
                begin
                    if (bcd_done)
                    begin
                        bcd_ok_reg <= 1'b1;
                        dig_reg    <= bcd << (lead * 4);
                        lead_reg   <= lead;
                    end
                    if (cal_done)
                    begin
                        cal_ok_reg <= 1'b1;
                        code_reg   <= {year[17:12], year[11:6], year[5:0], 2'b00, month0,
                                       1'b0, mday0, 1'b0, hour, minute, second,
                                       ns_reg[29:24], ns_reg[23:18], ns_reg[17:12],
                                       ns_reg[11:6], ns_reg[5:0]};
                    end
                    if (bcd_ok_reg && cal_ok_reg)
                    begin
                        dcnt_reg  <= 5'(DIG_N) - lead_reg;
                        state_reg <= S_DIGITS;
                    end
                end
                S_DIGITS:
                begin
                    if (free)
                    begin
                        ch_reg   <= CHAR_ZERO | {4'd0, dig_reg[DIG_N*4-1 -: 4]};
                        last_reg <= 1'b0;
                        dig_reg  <= {dig_reg[DIG_N*4-5:0], 4'd0};
                        dcnt_reg <= dcnt_reg - 5'd1;
                        if (dcnt_reg == 5'd1)
                        begin
                            ccnt_reg  <= (ns_reg != '0) ? 4'd13 : 4'd8;
                            state_reg <= S_CODES;
                        end
                    end
                end
                S_CODES:
                begin
                    if (free)
                    begin
                        ch_reg   <= code_char(code_reg[77:72]);
                        last_reg <= (ccnt_reg == 4'd1);
                        code_reg <= {code_reg[71:0], 6'd0};
                        ccnt_reg <= ccnt_reg - 4'd1;
                        if (ccnt_reg == 4'd1)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign out_valid = ov_reg;
    assign character = ch_reg;
    assign last      = last_reg;

endmodule

/* sv/tse_checker.sv */
// tse_checker: port-level assertions for timestamp_id_string_encoder
// depends on tse_pkg; bound to the top level below
module tse_checker
    import tse_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [7:0]        character,
    input logic              last
);

    logic open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= 1'b0;
        else if (in_valid && !in_stall)
            open_reg <= 1'b1;
        else if (out_valid && !out_stall && last)
            open_reg <= 1'b0;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(character) && $stable(last))
        else $error("output word changed while stalled");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid && character == CHAR_S)
        else $error("identifier does not open with S");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg && !(out_valid && !out_stall && last) |-> in_stall)
        else $error("input taken while an identifier is open");

    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg)
        else $error("output word with no open identifier");

endmodule

bind timestamp_id_string_encoder tse_checker u_tse_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .character(character), .last(last)
);
